// File: hdl/uls_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 log sanitizer package
// Shared beat types, character constants and the lead and hex lookups.
// ----------------------------------------------------------------------------
package uls_pkg;

    localparam int UNITS       = 4;
    localparam int HELD_DEPTH  = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] DEL_CHAR   = 8'h7F;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] BACKSLASH  = 8'h5C;
    localparam logic [7:0] LETTER_X   = 8'h78;

    localparam logic [1:0] SUB_SLASH = 2'd0;
    localparam logic [1:0] SUB_X     = 2'd1;
    localparam logic [1:0] SUB_HI    = 2'd2;
    localparam logic [1:0] SUB_LO    = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } t_out;

    typedef struct packed {
        logic [7:0] value;
        logic       esc;
    } t_unit;

    typedef struct packed {
        t_unit [UNITS-1:0] units;
        logic  [2:0]       count;
        logic              last;
    } t_cmd;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h37 + {4'h0, nib};
        end
        return c;
    endfunction

    // Total sequence length for a lead byte, zero when it is no valid lead.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b >= 8'hC2 && b <= 8'hDF) begin
            len = 3'd2;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            len = 3'd3;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

endpackage

// File: hdl/uls_front.sv
// ----------------------------------------------------------------------------
// UTF-8 log sanitizer front end
// Accepts input beats, tracks the open sequence and emits a command for each
// beat that releases bytes, listing them to pass, turn into a dot or escape.
// ----------------------------------------------------------------------------
module uls_front
    import uls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_data,
    output logic o_push,
    output t_cmd o_cmd
);

    logic [7:0] r_held [HELD_DEPTH];
    logic [1:0] r_hc;
    logic [2:0] r_exp;

    logic [7:0] n_held [HELD_DEPTH];
    logic [1:0] n_hc;
    logic [2:0] n_exp;

    t_cmd       w_cmd;
    logic [2:0] w_k;
    logic       w_lead;
    logic       w_cont_ok;
    logic [7:0] w_lo;
    logic [7:0] w_hi;
    logic [7:0] w_b;
    logic [2:0] w_len;

    assign w_b   = i_data.data_byte;
    assign w_len = lead_length(w_b);

    always_comb begin
        w_lo = 8'h80;
        w_hi = 8'hBF;
        if (r_hc == 2'd1) begin
            if (r_held[0] == 8'hE0) begin
                w_lo = 8'hA0;
            end else if (r_held[0] == 8'hED) begin
                w_hi = 8'h9F;
            end else if (r_held[0] == 8'hF0) begin
                w_lo = 8'h90;
            end else if (r_held[0] == 8'hF4) begin
                w_hi = 8'h8F;
            end
        end
        w_cont_ok = (w_b >= w_lo) && (w_b <= w_hi);
    end

    always_comb begin
        n_held = r_held;
        n_hc   = r_hc;
        n_exp  = r_exp;
        w_cmd  = '0;
        w_k    = 3'd0;
        w_lead = 1'b0;

        if (r_hc == 2'd0) begin
            w_lead = 1'b1;
        end else if (w_cont_ok) begin
            if ({1'b0, r_hc} + 3'd1 == r_exp) begin
                for (int i = 0; i < HELD_DEPTH; i++) begin
                    if (2'(i) < r_hc) begin
                        w_cmd.units[w_k[1:0]] = '{value: r_held[i], esc: 1'b0};
                        w_k = w_k + 3'd1;
                    end
                end
                w_cmd.units[w_k[1:0]] = '{value: w_b, esc: 1'b0};
                w_k   = w_k + 3'd1;
                n_hc  = 2'd0;
                n_exp = 3'd0;
            end else begin
                n_held[r_hc] = w_b;
                n_hc         = r_hc + 2'd1;
            end
        end else begin
            for (int i = 0; i < HELD_DEPTH; i++) begin
                if (2'(i) < r_hc) begin
                    w_cmd.units[w_k[1:0]] = '{value: r_held[i], esc: 1'b1};
                    w_k = w_k + 3'd1;
                end
            end
            n_hc   = 2'd0;
            n_exp  = 3'd0;
            w_lead = 1'b1;
        end

        if (w_lead) begin
            if (!w_b[7]) begin
                w_cmd.units[w_k[1:0]] = '{
                    value: (w_b < CTRL_LIMIT || w_b == DEL_CHAR) ? DOT_CHAR : w_b,
                    esc:   1'b0};
                w_k = w_k + 3'd1;
            end else if (w_len != 3'd0) begin
                n_held[0] = w_b;
                n_hc      = 2'd1;
                n_exp     = w_len;
            end else begin
                w_cmd.units[w_k[1:0]] = '{value: w_b, esc: 1'b1};
                w_k = w_k + 3'd1;
            end
        end

        if (i_data.end_of_text) begin
            for (int i = 0; i < HELD_DEPTH; i++) begin
                if (2'(i) < n_hc) begin
                    w_cmd.units[w_k[1:0]] = '{value: n_held[i], esc: 1'b1};
                    w_k = w_k + 3'd1;
                end
            end
            for (int i = 0; i < HELD_DEPTH; i++) begin
                n_held[i] = 8'h00;
            end
            n_hc  = 2'd0;
            n_exp = 3'd0;
        end

        w_cmd.count = w_k;
        w_cmd.last  = i_data.end_of_text;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HELD_DEPTH; i++) begin
                r_held[i] <= 8'h00;
            end
            r_hc  <= 2'd0;
            r_exp <= 3'd0;
        end else if (i_accept) begin
            r_held <= n_held;
            r_hc   <= n_hc;
            r_exp  <= n_exp;
        end
    end

    assign o_push = i_accept && (w_cmd.count != 3'd0);
    assign o_cmd  = w_cmd;

endmodule

// File: hdl/uls_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 log sanitizer command queue
// A short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module uls_queue
    import uls_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    logic w_do_push;
    logic w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_cmd     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: hdl/uls_back.sv
// ----------------------------------------------------------------------------
// UTF-8 log sanitizer back end
// Expands each command into output characters, one beat per cycle while the
// output is free or being popped, through a registered output stage.
// ----------------------------------------------------------------------------
module uls_back
    import uls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_q_empty,
    output logic o_q_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_out o_data
);

    logic [1:0] r_unit;
    logic [1:0] r_sub;
    t_out       r_out;
    logic       r_out_valid;

    t_unit      w_u;
    logic [7:0] w_char;
    logic       w_advance;
    logic       w_unit_done;
    logic       w_cmd_done;

    assign w_u         = i_cmd.units[r_unit];
    assign w_advance   = !i_q_empty && (!r_out_valid || i_pop);
    assign w_unit_done = !w_u.esc || (r_sub == SUB_LO);
    assign w_cmd_done  = w_unit_done && ({1'b0, r_unit} + 3'd1 == i_cmd.count);

    always_comb begin
        if (!w_u.esc) begin
            w_char = w_u.value;
        end else begin
            unique case (r_sub)
                SUB_SLASH: w_char = BACKSLASH;
                SUB_X:     w_char = LETTER_X;
                SUB_HI:    w_char = hex_digit(w_u.value[7:4]);
                SUB_LO:    w_char = hex_digit(w_u.value[3:0]);
                default:   w_char = BACKSLASH;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out.out_char <= w_char;
            r_out.out_last <= w_cmd_done && i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit      <= 2'd0;
            r_sub       <= 2'd0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
            if (w_unit_done) begin
                r_sub  <= 2'd0;
                r_unit <= w_cmd_done ? 2'd0 : r_unit + 2'd1;
            end else begin
                r_sub <= r_sub + 2'd1;
            end
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_q_pop = w_advance && w_cmd_done;
    assign o_empty = !r_out_valid;
    assign o_data  = r_out;

endmodule

// File: hdl/utf8_log_sanitizer.sv
// ----------------------------------------------------------------------------
// UTF-8 log sanitizer
// Validates a byte stream as UTF-8 and turns it into loggable text.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle while full is low, and one output beat leaves
// per cycle while pop is high and empty is low. A byte that passes through
// yields a single output character and an escaped byte a backslash, an x and
// two hex digits; the back end's one-character-per-cycle expander paces the
// output, and the command queue between front and back end, four entries by
// default, absorbs escape bursts before full rises. Bytes of a multi-byte
// sequence are held until the sequence completes or breaks, and out_last marks
// the final beat of a message.
module utf8_log_sanitizer
    import uls_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_data,
    output logic empty,
    input  logic pop,
    output t_out o_data
);

    logic w_accept;
    logic w_q_push;
    logic w_q_full;
    logic w_q_pop;
    logic w_q_empty;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    uls_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_data   (i_data),
        .o_push   (w_q_push),
        .o_cmd    (w_cmd_in)
    );

    uls_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_q_empty)
    );

    uls_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd_out),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_data    (o_data)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("Command written while the queue is full.");

    a_end_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.end_of_text) |-> (w_q_push && w_cmd_in.last))
        else $error("Final byte of a message produced no command.");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("Back end released a command from an empty queue.");

endmodule
